/* rtl/s2r_pkg.sv */
// Shared types and constants for the stack-to-register translator.
// Used by the channel interfaces and by the top level; depends on nothing.
package s2r_pkg;

  // Fixed payload widths of the channels.
  localparam int CMD_W = 3;
  localparam int OPND_W = 32;
  localparam int OP_W = 3;
  localparam int REG_W = 16;

  // Default configuration of the translator.
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VREG_BITS = 16;

  // Argument slot that a get-arg at the start of a body reads.
  localparam int GET_ARG_INDEX = 2;

  // Bytecode commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_LOCAL  = 3'd0,
    CMD_LOAD_GLOBAL = 3'd1,
    CMD_MAKE_LAMBDA = 3'd2,
    CMD_CALL        = 3'd3,
    CMD_RETURN      = 3'd4,
    CMD_MAKE_THUNK  = 3'd5,
    CMD_BEGIN       = 3'd6
  } cmd_t;

  // IR operations.
  typedef enum logic [OP_W-1:0] {
    OP_GET_ARG     = 3'd0,
    OP_LOAD_LOCAL  = 3'd1,
    OP_LOAD_GLOBAL = 3'd2,
    OP_MOVE_IMM    = 3'd3,
    OP_MAKE_LAMBDA = 3'd4,
    OP_MAKE_THUNK  = 3'd5,
    OP_APPLY       = 3'd6,
    OP_RETURN      = 3'd7
  } ir_op_t;

endpackage

/* rtl/s2r_ifs.sv */
// Valid/ready channel interfaces for bytecodes in and IR instructions out.
// Depends on s2r_pkg for the payload widths.
interface s2r_in_if;
  logic                         valid;
  logic                         ready;
  logic [s2r_pkg::CMD_W-1:0]    cmd;
  logic [s2r_pkg::OPND_W-1:0]   operand;

  modport source (output valid, cmd, operand, input ready);
  modport sink (input valid, cmd, operand, output ready);
endinterface

interface s2r_out_if;
  logic                         valid;
  logic                         ready;
  logic [s2r_pkg::OP_W-1:0]     ir_op;
  logic [s2r_pkg::REG_W-1:0]    dest_reg;
  logic                         dest_valid;
  logic [s2r_pkg::REG_W-1:0]    source_a;
  logic [s2r_pkg::REG_W-1:0]    source_b;
  logic [s2r_pkg::OPND_W-1:0]   immediate;
  logic                         last;
  logic                         error;

  modport source (output valid, ir_op, dest_reg, dest_valid, source_a, source_b,
                  immediate, last, error, input ready);
  modport sink (input valid, ir_op, dest_reg, dest_valid, source_a, source_b,
                immediate, last, error, output ready);
endinterface

/* rtl/stack_to_register_translator.sv */
// Stack-to-register translator top level: decode, register stack memory and
// output stage. Depends on s2r_pkg and the channel interfaces in s2r_ifs.sv.
//
//   channel    direction  payload                                      transfer
//   bytecode   in         cmd, operand                                 valid & ready
//   ir         out        ir_op, dest_reg, dest_valid, source_a,       valid & ready
//                         source_b, immediate, last, error
//
// A bytecode is decoded in the cycle it transfers; stack reads and the push
// go to the stack memory at that edge, and the read data is registered.
// Two register stages follow (decoded item, output beat), and an item shows on
// the ir channel from the output stage. One item per cycle is taken when the ir
// channel does not stall and each yields one IR instruction; make-lambda and
// make-thunk yield two and occupy the output stage for both beats. Synchronous
// reset clears the counters and both stages; the stack memory is not cleared.
// A stalled ir channel fills the output stage and then the decoded stage
// before the bytecode channel stalls.
module stack_to_register_translator #(
  parameter int STACK_DEPTH = s2r_pkg::DEF_STACK_DEPTH,
  parameter int VREG_BITS = s2r_pkg::DEF_VREG_BITS
) (
  input  logic              clk,
  input  logic              rst,
  s2r_in_if.sink            bytecode,
  s2r_out_if.source         ir
);

  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef logic [VREG_BITS-1:0] vreg_t;

  // One decoded item, as it travels through the two stages.
  typedef struct packed {
    s2r_pkg::ir_op_t             op;
    logic                        two;
    logic                        err;
    logic                        dest_valid;
    vreg_t                       dest;
    vreg_t                       tmp;
    vreg_t                       src_a;
    vreg_t                       src_b;
    logic [s2r_pkg::OPND_W-1:0]  imm;
    logic                        a_mem;
    logic                        b_mem;
  } item_t;

  // Control state.
  logic [DW-1:0] depth, depth_next;
  vreg_t         next_vreg, next_vreg_next;
  vreg_t         env_reg, env_reg_next;

  // Stage registers.
  logic   a_valid, b_valid, b_beat;
  item_t  a_item, b_item;
  item_t  dec_item, mov_item;
  logic   dec_emits;

  // Stack memory and its ports.
  vreg_t         stack_mem [STACK_DEPTH];
  vreg_t         rd_top, rd_below;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  vreg_t         wr_data;
  logic [DW-1:0] depth_m1, depth_m2;

  logic in_xfer, out_xfer, b_done, move;

  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);

  // Handshake between the stages.
  assign out_xfer = ir.valid && ir.ready;
  assign b_done = out_xfer && (!b_item.two || b_beat);
  assign move = a_valid && (!b_valid || b_done);
  assign bytecode.ready = !a_valid || move;
  assign in_xfer = bytecode.valid && bytecode.ready;

  // Decode of the incoming bytecode against the current stack and counter.
  always_comb begin
    dec_item = '0;
    dec_emits = 1'b1;
    depth_next = depth;
    next_vreg_next = next_vreg;
    env_reg_next = env_reg;
    wr_en = 1'b0;
    wr_addr = depth[AW-1:0];
    wr_data = next_vreg;
    case (bytecode.cmd)
      s2r_pkg::CMD_BEGIN: begin
        depth_next = '0;
        env_reg_next = '0;
        next_vreg_next = vreg_t'(1);
        dec_item.op = s2r_pkg::OP_GET_ARG;
        dec_item.dest_valid = 1'b1;
        dec_item.src_a = vreg_t'(s2r_pkg::GET_ARG_INDEX);
      end
      s2r_pkg::CMD_LOAD_LOCAL, s2r_pkg::CMD_LOAD_GLOBAL: begin
        if (depth >= DW'(STACK_DEPTH)) begin
          dec_item.err = 1'b1;
        end else begin
          next_vreg_next = next_vreg + vreg_t'(1);
          depth_next = depth + DW'(1);
          wr_en = 1'b1;
          dec_item.dest_valid = 1'b1;
          dec_item.dest = next_vreg;
          dec_item.imm = bytecode.operand;
          if (bytecode.cmd == s2r_pkg::CMD_LOAD_LOCAL) begin
            dec_item.op = s2r_pkg::OP_LOAD_LOCAL;
            dec_item.src_a = env_reg;
          end else begin
            dec_item.op = s2r_pkg::OP_LOAD_GLOBAL;
          end
        end
      end
      s2r_pkg::CMD_MAKE_LAMBDA, s2r_pkg::CMD_MAKE_THUNK: begin
        if (depth >= DW'(STACK_DEPTH)) begin
          dec_item.err = 1'b1;
        end else begin
          next_vreg_next = next_vreg + vreg_t'(2);
          depth_next = depth + DW'(1);
          wr_en = 1'b1;
          dec_item.two = 1'b1;
          dec_item.dest_valid = 1'b1;
          dec_item.dest = next_vreg;
          dec_item.tmp = next_vreg + vreg_t'(1);
          dec_item.src_a = next_vreg + vreg_t'(1);
          dec_item.src_b = env_reg;
          dec_item.imm = bytecode.operand;
          dec_item.op = (bytecode.cmd == s2r_pkg::CMD_MAKE_LAMBDA) ?
                        s2r_pkg::OP_MAKE_LAMBDA : s2r_pkg::OP_MAKE_THUNK;
        end
      end
      s2r_pkg::CMD_CALL: begin
        if (depth < DW'(2)) begin
          dec_item.err = 1'b1;
        end else begin
          // Pop two, push the result into the lower of the two slots.
          next_vreg_next = next_vreg + vreg_t'(1);
          depth_next = depth_m1;
          wr_en = 1'b1;
          wr_addr = depth_m2[AW-1:0];
          dec_item.op = s2r_pkg::OP_APPLY;
          dec_item.dest_valid = 1'b1;
          dec_item.dest = next_vreg;
          dec_item.a_mem = 1'b1;
          dec_item.b_mem = 1'b1;
        end
      end
      s2r_pkg::CMD_RETURN: begin
        if (depth == '0) begin
          dec_item.err = 1'b1;
        end else begin
          depth_next = depth_m1;
          dec_item.op = s2r_pkg::OP_RETURN;
          dec_item.a_mem = 1'b1;
        end
      end
      default: begin
        dec_emits = 1'b0;
      end
    endcase
  end

  // Stack memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_xfer && wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_top <= stack_mem[depth_m1[AW-1:0]];
      rd_below <= stack_mem[depth_m2[AW-1:0]];
    end
  end

  // Fold the read data into the item as it leaves the decoded stage.
  always_comb begin
    mov_item = a_item;
    if (a_item.a_mem) begin
      mov_item.src_a = rd_top;
    end
    if (a_item.b_mem) begin
      mov_item.src_b = rd_below;
    end
  end

  // Control state and stage payloads.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      next_vreg <= '0;
      env_reg <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      b_beat <= 1'b0;
    end else begin
      if (in_xfer) begin
        depth <= depth_next;
        next_vreg <= next_vreg_next;
        env_reg <= env_reg_next;
      end
      if (in_xfer && dec_emits) begin
        a_valid <= 1'b1;
      end else if (move) begin
        a_valid <= 1'b0;
      end
      if (move) begin
        b_valid <= 1'b1;
        b_beat <= 1'b0;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end else if (out_xfer) begin
        b_beat <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_item <= dec_item;
    end
    if (move) begin
      b_item <= mov_item;
    end
  end

  // Output beat: the move-immediate first for two-instruction items.
  always_comb begin
    ir.valid = b_valid;
    ir.error = b_item.err;
    if (b_item.two && !b_beat) begin
      ir.ir_op = s2r_pkg::OP_MOVE_IMM;
      ir.dest_reg = s2r_pkg::REG_W'(b_item.tmp);
      ir.dest_valid = 1'b1;
      ir.source_a = '0;
      ir.source_b = '0;
      ir.immediate = b_item.imm;
      ir.last = 1'b0;
    end else begin
      ir.ir_op = b_item.op;
      ir.dest_reg = s2r_pkg::REG_W'(b_item.dest);
      ir.dest_valid = b_item.dest_valid;
      ir.source_a = s2r_pkg::REG_W'(b_item.src_a);
      ir.source_b = s2r_pkg::REG_W'(b_item.src_b);
      ir.immediate = b_item.two ? '0 : b_item.imm;
      ir.last = 1'b1;
    end
  end

  // The stack count never passes the memory depth.
  assert property (@(posedge clk) disable iff (rst) depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond memory size");

  // A transfer without last is followed at once by the rest of the item.
  assert property (@(posedge clk) disable iff (rst) out_xfer && !ir.last |=> ir.valid)
    else $error("second instruction of an item missing");

  // A dropped item is a single beat with no destination.
  assert property (@(posedge clk) disable iff (rst)
      ir.valid && ir.error |-> ir.last && !ir.dest_valid)
    else $error("error beat malformed");

  // A begin clears the stack and hands out register zero to the environment.
  assert property (@(posedge clk) disable iff (rst)
      in_xfer && bytecode.cmd == s2r_pkg::CMD_BEGIN
      |=> depth == '0 && next_vreg == vreg_t'(1) && env_reg == '0)
    else $error("begin did not reset the translator state");

endmodule
